// ===== hdl/mms_pkg.sv =====
// Shared types, codes and helpers for the MNA matrix stamper.
package mms_pkg;

  // Field widths fixed by the item and result formats
  localparam int KIND_W = 4;
  localparam int NODE_W = 5;
  localparam int CSRC_W = 4;
  localparam int VAL_W  = 32;
  localparam int RC_W   = 5;
  localparam int STAT_W = 3;
  localparam int USED_W = 5;
  localparam int CFG_W  = 5;

  // Default sizes of the system
  localparam int MAX_NODES_DEF   = 16;
  localparam int MAX_SOURCES_DEF = 16;

  // Row/column width carried in update slots (covers up to 128 rows)
  localparam int ADDR_W = 7;
  // Update slots per command and command queue depth
  localparam int NSTEP  = 7;
  localparam int QDEPTH = 2;

  // Element kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RES   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ISRC  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_VSRC  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_VCVS  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CCCS  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_VCCS  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CCVS  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RDMAT = 4'd8;
  localparam logic [KIND_W-1:0] KIND_RDRHS = 4'd9;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_RES = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

  // Configuration register indexes
  localparam logic CFG_NODES   = 1'b0;
  localparam logic CFG_SOURCES = 1'b1;

  // Back-end operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_STEPS = 2'd3;

  // Operand source of one update
  localparam logic [1:0] SRC_VAL  = 2'd0;
  localparam logic [1:0] SRC_ONE  = 2'd1;
  localparam logic [1:0] SRC_G    = 2'd2;
  localparam logic [1:0] SRC_ZERO = 2'd3;

  localparam logic signed [VAL_W-1:0] ONE_Q = 32'sh0001_0000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [NODE_W-1:0]       plus_node;
    logic [NODE_W-1:0]       minus_node;
    logic [NODE_W-1:0]       ctrl_pos;
    logic [NODE_W-1:0]       ctrl_neg;
    logic [CSRC_W-1:0]       ctrl_source;
    logic signed [VAL_W-1:0] value;
    logic [RC_W-1:0]         row;
    logic [RC_W-1:0]         col;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] entry_data;
    logic [USED_W-1:0]       sources_used;
  } result_t;

  // One read-modify-write (or set) of a matrix or rhs entry
  typedef struct packed {
    logic              en;
    logic              is_rhs;
    logic              is_set;
    logic              neg;
    logic [1:0]        src;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
  } step_t;

  typedef struct packed {
    logic [1:0]              op;
    logic                    is_res;
    logic [STAT_W-1:0]       status;
    logic [USED_W-1:0]       used;
    logic signed [VAL_W-1:0] value;
    step_t [NSTEP-1:0]       steps;
  } cmd_t;

  function automatic step_t mk_step(logic en, logic is_rhs, logic is_set, logic neg,
                                    logic [1:0] src, logic [ADDR_W-1:0] r,
                                    logic [ADDR_W-1:0] c);
    step_t s;
    s.en     = en;
    s.is_rhs = is_rhs;
    s.is_set = is_set;
    s.neg    = neg;
    s.src    = src;
    s.row    = r;
    s.col    = c;
    return s;
  endfunction

endpackage

// ===== hdl/mms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mms_front.sv =====
// Front end: configuration registers, item checks, source row counter, command build.
module mms_front #(
  parameter int MAX_NODES   = mms_pkg::MAX_NODES_DEF,
  parameter int MAX_SOURCES = mms_pkg::MAX_SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [mms_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  mms_pkg::item_t             item,
  input  logic                       q_full,
  input  logic                       init_busy,
  output logic                       push,
  output mms_pkg::cmd_t              cmd
);

  localparam int CMP_W = $clog2(MAX_NODES + MAX_SOURCES + 32) + 1;
  localparam int CTR_W = $clog2(MAX_SOURCES + 1);

  logic [mms_pkg::CFG_W-1:0] nodes_cfg;
  logic [mms_pkg::CFG_W-1:0] srcs_cfg;
  logic [CTR_W-1:0]          counter;
  logic [CTR_W-1:0]          counter_next;

  logic [CMP_W-1:0] n, m, dim, k, ncs;
  logic [CMP_W-1:0] p, q, cp, cn;
  logic [mms_pkg::ADDR_W-1:0] p_a, q_a, cp_a, cn_a, k_a, ncs_a, row_a, col_a;
  logic nodes_ok, ctrl_ok, cs_ok, row_ok, col_ok, is_vsrc, do_clear, do_src;
  logic pz, qz, cpz, cnz;

  assign cfg_ready  = 1'b1;
  assign item_ready = !q_full && !init_busy;
  assign push       = item_valid && item_ready;

  // Clamp registers and form indexes
  always_comb begin
    n   = (CMP_W'(nodes_cfg) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : CMP_W'(nodes_cfg);
    m   = (CMP_W'(srcs_cfg) > CMP_W'(MAX_SOURCES)) ? CMP_W'(MAX_SOURCES) : CMP_W'(srcs_cfg);
    dim = n + m;
    k   = n + CMP_W'(counter);
    ncs = n + CMP_W'(item.ctrl_source);
    p   = CMP_W'(item.plus_node);
    q   = CMP_W'(item.minus_node);
    cp  = CMP_W'(item.ctrl_pos);
    cn  = CMP_W'(item.ctrl_neg);
    pz  = (p == '0);
    qz  = (q == '0);
    cpz = (cp == '0);
    cnz = (cn == '0);
    p_a   = mms_pkg::ADDR_W'(p - CMP_W'(1));
    q_a   = mms_pkg::ADDR_W'(q - CMP_W'(1));
    cp_a  = mms_pkg::ADDR_W'(cp - CMP_W'(1));
    cn_a  = mms_pkg::ADDR_W'(cn - CMP_W'(1));
    k_a   = mms_pkg::ADDR_W'(k);
    ncs_a = mms_pkg::ADDR_W'(ncs);
    row_a = mms_pkg::ADDR_W'(item.row);
    col_a = mms_pkg::ADDR_W'(item.col);
    nodes_ok = (p <= n) && (q <= n);
    ctrl_ok  = (cp <= n) && (cn <= n);
    cs_ok    = (CMP_W'(item.ctrl_source) < m);
    row_ok   = (CMP_W'(item.row) < dim);
    col_ok   = (CMP_W'(item.col) < dim);
    is_vsrc  = (item.kind == mms_pkg::KIND_VSRC) || (item.kind == mms_pkg::KIND_VCVS) ||
               (item.kind == mms_pkg::KIND_CCVS);
  end

  // Classify the item and build its update list
  always_comb begin
    cmd        = '0;
    cmd.value  = item.value;
    cmd.status = mms_pkg::STAT_OK;
    cmd.op     = mms_pkg::OP_NONE;
    do_clear   = 1'b0;
    do_src     = 1'b0;
    priority if (item.kind > mms_pkg::KIND_RDRHS) begin
      cmd.status = mms_pkg::STAT_UNKNOWN;
    end else if (item.kind == mms_pkg::KIND_CLEAR) begin
      cmd.op   = mms_pkg::OP_CLEAR;
      do_clear = 1'b1;
    end else if (item.kind == mms_pkg::KIND_RDMAT) begin
      if (row_ok && col_ok) begin
        cmd.op       = mms_pkg::OP_READ;
        cmd.steps[0] = mms_pkg::mk_step(1'b1, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_ZERO, row_a, col_a);
      end else begin
        cmd.status = mms_pkg::STAT_RANGE;
      end
    end else if (item.kind == mms_pkg::KIND_RDRHS) begin
      if (row_ok) begin
        cmd.op       = mms_pkg::OP_READ;
        cmd.steps[0] = mms_pkg::mk_step(1'b1, 1'b1, 1'b0, 1'b0, mms_pkg::SRC_ZERO, row_a, col_a);
      end else begin
        cmd.status = mms_pkg::STAT_RANGE;
      end
    end else if (!nodes_ok ||
                 (((item.kind == mms_pkg::KIND_VCVS) || (item.kind == mms_pkg::KIND_VCCS))
                  && !ctrl_ok) ||
                 (((item.kind == mms_pkg::KIND_CCCS) || (item.kind == mms_pkg::KIND_CCVS))
                  && !cs_ok)) begin
      cmd.status = mms_pkg::STAT_RANGE;
    end else if ((item.kind == mms_pkg::KIND_RES) && (item.value == '0)) begin
      cmd.status = mms_pkg::STAT_ZERO_RES;
    end else if (is_vsrc && (CMP_W'(counter) >= m)) begin
      cmd.status = mms_pkg::STAT_OVERFLOW;
    end else if (item.kind == mms_pkg::KIND_RES) begin
      cmd.op       = mms_pkg::OP_STEPS;
      cmd.is_res   = 1'b1;
      cmd.steps[0] = mms_pkg::mk_step(!pz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_G, p_a, p_a);
      cmd.steps[1] = mms_pkg::mk_step(!qz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_G, q_a, q_a);
      cmd.steps[2] = mms_pkg::mk_step(!pz && !qz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_G, p_a, q_a);
      cmd.steps[3] = mms_pkg::mk_step(!pz && !qz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_G, q_a, p_a);
    end else if (item.kind == mms_pkg::KIND_ISRC) begin
      cmd.op       = mms_pkg::OP_STEPS;
      cmd.steps[0] = mms_pkg::mk_step(!pz, 1'b1, 1'b0, 1'b1, mms_pkg::SRC_VAL, p_a, p_a);
      cmd.steps[1] = mms_pkg::mk_step(!qz, 1'b1, 1'b0, 1'b0, mms_pkg::SRC_VAL, q_a, q_a);
    end else if (item.kind == mms_pkg::KIND_CCCS) begin
      cmd.op       = mms_pkg::OP_STEPS;
      cmd.steps[0] = mms_pkg::mk_step(!pz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_VAL, p_a, ncs_a);
      cmd.steps[1] = mms_pkg::mk_step(!qz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_VAL, q_a, ncs_a);
    end else if (item.kind == mms_pkg::KIND_VCCS) begin
      cmd.op       = mms_pkg::OP_STEPS;
      cmd.steps[0] = mms_pkg::mk_step(!pz && !cpz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_VAL, p_a, cp_a);
      cmd.steps[1] = mms_pkg::mk_step(!pz && !cnz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_VAL, p_a, cn_a);
      cmd.steps[2] = mms_pkg::mk_step(!qz && !cpz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_VAL, q_a, cp_a);
      cmd.steps[3] = mms_pkg::mk_step(!qz && !cnz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_VAL, q_a, cn_a);
    end else begin
      // Voltage-type source on its own row k
      cmd.op       = mms_pkg::OP_STEPS;
      do_src       = 1'b1;
      cmd.steps[0] = mms_pkg::mk_step(!pz, 1'b0, 1'b1, 1'b0, mms_pkg::SRC_ONE, p_a, k_a);
      cmd.steps[1] = mms_pkg::mk_step(!pz, 1'b0, 1'b1, 1'b0, mms_pkg::SRC_ONE, k_a, p_a);
      cmd.steps[2] = mms_pkg::mk_step(!qz, 1'b0, 1'b1, 1'b1, mms_pkg::SRC_ONE, q_a, k_a);
      cmd.steps[3] = mms_pkg::mk_step(!qz, 1'b0, 1'b1, 1'b1, mms_pkg::SRC_ONE, k_a, q_a);
      if (item.kind == mms_pkg::KIND_VCVS) begin
        cmd.steps[4] = mms_pkg::mk_step(!cpz, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_VAL, k_a, cp_a);
        cmd.steps[5] = mms_pkg::mk_step(!cnz, 1'b0, 1'b0, 1'b0, mms_pkg::SRC_VAL, k_a, cn_a);
      end else if (item.kind == mms_pkg::KIND_CCVS) begin
        cmd.steps[4] = mms_pkg::mk_step(1'b1, 1'b0, 1'b0, 1'b1, mms_pkg::SRC_VAL, k_a, ncs_a);
      end
      cmd.steps[6] = mms_pkg::mk_step(1'b1, 1'b1, 1'b1, 1'b0,
                                      (item.kind == mms_pkg::KIND_VSRC) ?
                                      mms_pkg::SRC_VAL : mms_pkg::SRC_ZERO, k_a, k_a);
    end

    priority if (do_clear) begin
      counter_next = '0;
    end else if (do_src) begin
      counter_next = counter + CTR_W'(1);
    end else begin
      counter_next = counter;
    end
    cmd.used = mms_pkg::USED_W'(counter_next);
  end

  // Hold registers and advance the source counter
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_cfg <= mms_pkg::CFG_W'(16);
      srcs_cfg  <= '0;
      counter   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mms_pkg::CFG_NODES:   nodes_cfg <= cfg_data;
          mms_pkg::CFG_SOURCES: srcs_cfg  <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        counter <= counter_next;
      end
    end
  end

endmodule

// ===== hdl/mms_queue.sv =====
// Short command queue between the front and back ends.
module mms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mms_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output mms_pkg::cmd_t head
);

  localparam int PW = $clog2(mms_pkg::QDEPTH);

  mms_pkg::cmd_t  slots [mms_pkg::QDEPTH];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(mms_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rp];

  // Store beats and move pointers
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(mms_pkg::QDEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(mms_pkg::QDEPTH - 1)) ? '0 : rp + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== hdl/mms_back.sv =====
// Back end: reciprocal divider, read-modify-write sequencer, clear sweep, result register.
module mms_back #(
  parameter int MAX_NODES   = mms_pkg::MAX_NODES_DEF,
  parameter int MAX_SOURCES = mms_pkg::MAX_SOURCES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  mms_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             init_busy,
  output logic             result_valid,
  input  logic             result_ready,
  output mms_pkg::result_t result
);

  localparam int IW       = $clog2(MAX_NODES + MAX_SOURCES);
  localparam int MDEPTH   = 1 << (2 * IW);
  localparam int RDEPTH   = 1 << IW;
  localparam int DIV_N    = 34;
  localparam int DCNT_W   = $clog2(DIV_N);
  localparam int SIDX_W   = $clog2(mms_pkg::NSTEP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_READW = 3'd6;

  logic [2:0]         state;
  logic               init;
  mms_pkg::cmd_t      cmd;
  logic [SIDX_W-1:0]  idx;
  logic [2*IW-1:0]    clr;
  logic [DIV_N-1:0]   div_num;
  logic [32:0]        div_rem;
  logic [DIV_N-1:0]   div_quo;
  logic [DCNT_W-1:0]  div_cnt;
  logic [31:0]        mag;
  logic               out_valid;
  mms_pkg::result_t   out;

  mms_pkg::step_t     cur;
  logic               last;
  logic [32:0]        div_try;
  logic               div_ge;
  logic signed [31:0] g_sat;
  logic signed [32:0] base, delta;
  logic signed [31:0] old, upd;
  logic signed [33:0] sum;
  logic [31:0]        mag_new;

  logic               mat_we, rhs_we;
  logic [2*IW-1:0]    mat_waddr, mat_raddr;
  logic [IW-1:0]      rhs_waddr, rhs_raddr;
  logic [31:0]        mat_wdata, rhs_wdata, mat_rdata, rhs_rdata;

  mms_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  mms_ram #(.WIDTH(32), .DEPTH(RDEPTH)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata),
    .raddr(rhs_raddr), .rdata(rhs_rdata)
  );

  assign result_valid = out_valid;
  assign result       = out;
  assign init_busy    = init;
  assign q_pop        = (state == ST_IDLE) && q_valid && !out_valid;

  // Current slot and divider step
  always_comb begin
    cur     = cmd.steps[idx];
    last    = (idx == SIDX_W'(mms_pkg::NSTEP - 1));
    div_try = {div_rem[31:0], div_num[DIV_N-1]};
    div_ge  = (div_try >= {1'b0, mag});
    mag_new = q_cmd.value[31] ? 32'(-q_cmd.value) : 32'(q_cmd.value);
  end

  // Saturate the conductance
  always_comb begin
    if (!cmd.value[31]) begin
      g_sat = (div_quo > DIV_N'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : div_quo[31:0];
    end else begin
      g_sat = (div_quo > DIV_N'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-div_quo);
    end
  end

  // Update value with saturation
  always_comb begin
    unique case (cur.src)
      mms_pkg::SRC_VAL:  base = 33'(cmd.value);
      mms_pkg::SRC_ONE:  base = 33'(mms_pkg::ONE_Q);
      mms_pkg::SRC_G:    base = 33'(g_sat);
      mms_pkg::SRC_ZERO: base = '0;
      default:           base = '0;
    endcase
    delta = cur.neg ? -base : base;
    old   = cur.is_rhs ? rhs_rdata : mat_rdata;
    sum   = 34'(old) + 34'(delta);
    if (cur.is_set) begin
      upd = delta[31:0];
    end else if (sum > 34'sh0_7FFF_FFFF) begin
      upd = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      upd = 32'sh8000_0000;
    end else begin
      upd = sum[31:0];
    end
  end

  // Memory ports
  always_comb begin
    mat_raddr = {cur.row[IW-1:0], cur.col[IW-1:0]};
    rhs_raddr = cur.row[IW-1:0];
    mat_we    = 1'b0;
    rhs_we    = 1'b0;
    mat_waddr = {cur.row[IW-1:0], cur.col[IW-1:0]};
    rhs_waddr = cur.row[IW-1:0];
    mat_wdata = upd;
    rhs_wdata = upd;
    if (state == ST_CLEAR) begin
      mat_we    = 1'b1;
      mat_waddr = clr;
      mat_wdata = '0;
      rhs_we    = (clr[2*IW-1:IW] == '0);
      rhs_waddr = clr[IW-1:0];
      rhs_wdata = '0;
    end else if (state == ST_RMW) begin
      mat_we = !cur.is_rhs;
      rhs_we = cur.is_rhs;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init      <= 1'b1;
      clr       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cmd <= q_cmd;
            idx <= '0;
            unique case (q_cmd.op)
              mms_pkg::OP_CLEAR: begin
                clr   <= '0;
                state <= ST_CLEAR;
              end
              mms_pkg::OP_READ: state <= ST_READ;
              mms_pkg::OP_STEPS: begin
                if (q_cmd.is_res) begin
                  mag     <= mag_new;
                  div_num <= DIV_N'(34'h1_0000_0000) + DIV_N'(mag_new[31:1]);
                  div_rem <= '0;
                  div_quo <= '0;
                  div_cnt <= '0;
                  state   <= ST_DIV;
                end else begin
                  state <= ST_STEP;
                end
              end
              default: begin
                out_valid <= 1'b1;
                out       <= '{q_cmd.status, 32'sd0, q_cmd.used};
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr <= clr + (2*IW)'(1);
          if (clr == '1) begin
            if (init) begin
              init  <= 1'b0;
              state <= ST_IDLE;
            end else begin
              out_valid <= 1'b1;
              out       <= '{cmd.status, 32'sd0, cmd.used};
              state     <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? div_try - {1'b0, mag} : div_try;
          div_num <= {div_num[DIV_N-2:0], 1'b0};
          div_quo <= {div_quo[DIV_N-2:0], div_ge};
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(DIV_N - 1)) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (cur.en) begin
            state <= ST_RMW;
          end else if (last) begin
            out_valid <= 1'b1;
            out       <= '{cmd.status, 32'sd0, cmd.used};
            state     <= ST_IDLE;
          end else begin
            idx <= idx + SIDX_W'(1);
          end
        end
        ST_RMW: begin
          if (last) begin
            out_valid <= 1'b1;
            out       <= '{cmd.status, 32'sd0, cmd.used};
            state     <= ST_IDLE;
          end else begin
            idx   <= idx + SIDX_W'(1);
            state <= ST_STEP;
          end
        end
        ST_READ: state <= ST_READW;
        ST_READW: begin
          out_valid <= 1'b1;
          out       <= '{cmd.status, cur.is_rhs ? rhs_rdata : mat_rdata, cmd.used};
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mat_we && !rhs_we)
    else $error("memory written while idle");

  a_pop_free_out: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !out_valid)
    else $error("command taken while result still pending");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < DCNT_W'(DIV_N))
    else $error("divider ran past its last step");

  a_init_state: assert property (@(posedge clk) disable iff (rst)
    init |-> state == ST_CLEAR)
    else $error("reset sweep left unfinished");

endmodule

// ===== hdl/mna_matrix_stamper.sv =====
// Top level of the MNA matrix stamper: front end, command queue, back end.
//
// Stamps one circuit element per item into a DC MNA matrix and rhs held in
// RAM, or clears or reads them; every item returns one result beat. The
// front end checks and queues items at one per cycle while the queue has
// room and no reset sweep runs; the back end runs one command at a time and
// takes the next one only after the previous result beat has been accepted.
// A stamp walks the slots of its seven-slot update list, reading and writing
// back each entry it updates and skipping unused slots; a resistor first
// forms its conductance in the bit-serial reciprocal divider, and a read
// returns the registered RAM data. A clear walks all matrix RAM entries,
// 2^(2*ceil(log2(MAX_NODES+MAX_SOURCES))) (1024 by default), one per cycle,
// and the same sweep runs after reset while item_ready stays low. Throughput
// is set by the back end, which updates one RAM entry at a time.
module mna_matrix_stamper #(
  parameter int MAX_NODES   = mms_pkg::MAX_NODES_DEF,
  parameter int MAX_SOURCES = mms_pkg::MAX_SOURCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [mms_pkg::CFG_W-1:0] cfg_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  mms_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output mms_pkg::result_t          result
);

  logic          push, q_full, q_valid, q_pop, init_busy;
  mms_pkg::cmd_t push_cmd, q_cmd;

  mms_front #(.MAX_NODES(MAX_NODES), .MAX_SOURCES(MAX_SOURCES)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .q_full(q_full), .init_busy(init_busy), .push(push), .cmd(push_cmd)
  );

  mms_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_cmd)
  );

  mms_back #(.MAX_NODES(MAX_NODES), .MAX_SOURCES(MAX_SOURCES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .init_busy(init_busy),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

endmodule

// ===== bench/tb_mna_matrix_stamper.sv =====
// Self-checking testbench for the MNA matrix stamper: random and directed items.
`timescale 1ns / 1ps

module tb_mna_matrix_stamper;

  localparam int DIM         = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 1200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_index = mms_pkg::CFG_NODES;
  logic [mms_pkg::CFG_W-1:0] cfg_data = '0;
  logic    item_valid = 1'b0;
  logic    item_ready;
  mms_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  mms_pkg::result_t result;

  mna_matrix_stamper dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the system and the registers
  int          shadow_mat[DIM*DIM];
  int          shadow_rhs[DIM];
  int unsigned shadow_count;
  int unsigned reg_nodes;
  int unsigned reg_sources;

  mms_pkg::item_t   pending_items[$];
  mms_pkg::result_t expected_results[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      beat_taken = 1'b0;
  int      burst_left = 4;
  int      gap_left = 0;
  int      hold_cnt = 0;
  int      stall_pct = 0;
  bit      long_hold_req = 1'b0;
  bit      long_hold_done = 1'b0;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic void mat_accum(int unsigned r, int unsigned c, longint d);
    if (r < DIM && c < DIM)
      shadow_mat[r*DIM+c] = sat32(longint'(shadow_mat[r*DIM+c]) + d);
  endfunction

  function automatic void rhs_accum(int unsigned r, longint d);
    if (r < DIM) shadow_rhs[r] = sat32(longint'(shadow_rhs[r]) + d);
  endfunction

  function automatic void mat_put(int unsigned r, int unsigned c, int v);
    if (r < DIM && c < DIM) shadow_mat[r*DIM+c] = v;
  endfunction

  function automatic void wipe_system();
    foreach (shadow_mat[i]) shadow_mat[i] = 0;
    foreach (shadow_rhs[i]) shadow_rhs[i] = 0;
    shadow_count = 0;
  endfunction

  // Apply one item to the shadow system and return its result
  function automatic mms_pkg::result_t stamp_element(mms_pkg::item_t it);
    int unsigned n, m, dim, k, p, q, cp, cn, cs, rw, cl;
    longint      v, g, mag, quo;
    bit          nodes_ok, ctrl_ok, is_vsrc;
    mms_pkg::result_t r;
    n = (reg_nodes > mms_pkg::MAX_NODES_DEF) ? mms_pkg::MAX_NODES_DEF : reg_nodes;
    m = (reg_sources > mms_pkg::MAX_SOURCES_DEF) ? mms_pkg::MAX_SOURCES_DEF : reg_sources;
    dim = n + m;
    p = it.plus_node; q = it.minus_node; cp = it.ctrl_pos; cn = it.ctrl_neg;
    cs = it.ctrl_source; rw = it.row; cl = it.col;
    v = longint'(it.value);
    k = n + shadow_count;
    nodes_ok = (p <= n) && (q <= n);
    ctrl_ok = (cp <= n) && (cn <= n);
    is_vsrc = (it.kind == mms_pkg::KIND_VSRC) || (it.kind == mms_pkg::KIND_VCVS) ||
              (it.kind == mms_pkg::KIND_CCVS);
    r.status = mms_pkg::STAT_OK;
    r.entry_data = 0;
    if (it.kind > mms_pkg::KIND_RDRHS) begin
      r.status = mms_pkg::STAT_UNKNOWN;
    end else if (it.kind == mms_pkg::KIND_CLEAR) begin
      wipe_system();
    end else if (it.kind == mms_pkg::KIND_RDMAT) begin
      if (rw < dim && cl < dim) r.entry_data = shadow_mat[rw*DIM+cl];
      else r.status = mms_pkg::STAT_RANGE;
    end else if (it.kind == mms_pkg::KIND_RDRHS) begin
      if (rw < dim) r.entry_data = shadow_rhs[rw];
      else r.status = mms_pkg::STAT_RANGE;
    end else if (!nodes_ok ||
                 ((it.kind == mms_pkg::KIND_VCVS || it.kind == mms_pkg::KIND_VCCS) &&
                  !ctrl_ok) ||
                 ((it.kind == mms_pkg::KIND_CCCS || it.kind == mms_pkg::KIND_CCVS) &&
                  cs >= m)) begin
      r.status = mms_pkg::STAT_RANGE;
    end else if (it.kind == mms_pkg::KIND_RES && v == 0) begin
      r.status = mms_pkg::STAT_ZERO_RES;
    end else if (is_vsrc && shadow_count >= m) begin
      r.status = mms_pkg::STAT_OVERFLOW;
    end else if (it.kind == mms_pkg::KIND_RES) begin
      // Conductance rounded half away from zero
      mag = (v < 0) ? -v : v;
      quo = ((64'sd1 <<< 32) + mag / 2) / mag;
      g = sat32((v < 0) ? -quo : quo);
      if (p != 0) mat_accum(p-1, p-1, g);
      if (q != 0) mat_accum(q-1, q-1, g);
      if (p != 0 && q != 0) begin
        mat_accum(p-1, q-1, -g);
        mat_accum(q-1, p-1, -g);
      end
    end else if (it.kind == mms_pkg::KIND_ISRC) begin
      if (p != 0) rhs_accum(p-1, -v);
      if (q != 0) rhs_accum(q-1, v);
    end else if (it.kind == mms_pkg::KIND_CCCS) begin
      if (p != 0) mat_accum(p-1, n+cs, v);
      if (q != 0) mat_accum(q-1, n+cs, -v);
    end else if (it.kind == mms_pkg::KIND_VCCS) begin
      if (p != 0 && cp != 0) mat_accum(p-1, cp-1, v);
      if (p != 0 && cn != 0) mat_accum(p-1, cn-1, -v);
      if (q != 0 && cp != 0) mat_accum(q-1, cp-1, -v);
      if (q != 0 && cn != 0) mat_accum(q-1, cn-1, v);
    end else begin
      if (p != 0) begin
        mat_put(p-1, k, mms_pkg::ONE_Q);
        mat_put(k, p-1, mms_pkg::ONE_Q);
      end
      if (q != 0) begin
        mat_put(q-1, k, -mms_pkg::ONE_Q);
        mat_put(k, q-1, -mms_pkg::ONE_Q);
      end
      if (it.kind == mms_pkg::KIND_VCVS) begin
        if (cp != 0) mat_accum(k, cp-1, -v);
        if (cn != 0) mat_accum(k, cn-1, v);
      end else if (it.kind == mms_pkg::KIND_CCVS) begin
        mat_accum(k, n+cs, -v);
      end
      if (k < DIM) shadow_rhs[k] = (it.kind == mms_pkg::KIND_VSRC) ? int'(v) : 0;
      shadow_count++;
    end
    r.sources_used = shadow_count[mms_pkg::USED_W-1:0];
    return r;
  endfunction

  // Drive item beats in bursts with gaps
  always @(negedge clk) begin
    if (!item_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Stall the result side; one long hold-off fills the block
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_cnt = 3000;
    end
    if (cycle_count % 97 == 0)
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 80);
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Predict on accepted items, check accepted results
  always @(posedge clk) begin
    mms_pkg::result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      if (item_valid && item_ready) begin
        beat_taken = 1'b1;
        expected_results.push_back(stamp_element(item));
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status || result.entry_data !== want.entry_data ||
              result.sources_used !== want.sources_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected st=%0d data=%h used=%0d,",
                        " got st=%0d data=%h used=%0d"},
                       want.status, want.entry_data, want.sources_used,
                       result.status, result.entry_data, result.sources_used);
          end
        end
      end
    end
  end

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[mms_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == mms_pkg::CFG_NODES) reg_nodes = val[mms_pkg::CFG_W-1:0];
    else reg_sources = val[mms_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic mms_pkg::item_t build_item(logic [mms_pkg::KIND_W-1:0] kind,
                                                int p, int q, int cp, int cn,
                                                int cs, int val, int rw, int cl);
    mms_pkg::item_t it;
    it.kind        = kind;
    it.plus_node   = mms_pkg::NODE_W'(p);
    it.minus_node  = mms_pkg::NODE_W'(q);
    it.ctrl_pos    = mms_pkg::NODE_W'(cp);
    it.ctrl_neg    = mms_pkg::NODE_W'(cn);
    it.ctrl_source = mms_pkg::CSRC_W'(cs);
    it.value       = val;
    it.row         = mms_pkg::RC_W'(rw);
    it.col         = mms_pkg::RC_W'(cl);
    return it;
  endfunction

  function automatic int pick_node(int n);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, n);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $urandom_range(1, 4);
      4: return $urandom();
      default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
    endcase
  endfunction

  // Mostly valid stamps and reads, with some noise
  function automatic mms_pkg::item_t random_item();
    int unsigned n, m, dim, sel;
    logic [mms_pkg::KIND_W-1:0] kind;
    n = (reg_nodes > mms_pkg::MAX_NODES_DEF) ? mms_pkg::MAX_NODES_DEF : reg_nodes;
    m = (reg_sources > mms_pkg::MAX_SOURCES_DEF) ? mms_pkg::MAX_SOURCES_DEF : reg_sources;
    dim = n + m;
    sel = $urandom_range(0, 99);
    if (sel < 2) kind = mms_pkg::KIND_CLEAR;
    else if (sel < 4) kind = mms_pkg::KIND_W'($urandom_range(10, 15));
    else if (sel < 20) kind = mms_pkg::KIND_RDMAT;
    else if (sel < 30) kind = mms_pkg::KIND_RDRHS;
    else kind = mms_pkg::KIND_W'($urandom_range(1, 7));
    return build_item(kind, pick_node(n), pick_node(n), pick_node(n), pick_node(n),
                      ($urandom_range(0, 7) == 0 || m == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(0, m-1),
                      pick_value(),
                      ($urandom_range(0, 9) == 0 || dim == 0) ? $urandom_range(0, 31)
                                                              : $urandom_range(0, dim-1),
                      ($urandom_range(0, 9) == 0 || dim == 0) ? $urandom_range(0, 31)
                                                              : $urandom_range(0, dim-1));
  endfunction

  initial begin
    int node_set[7]   = '{16, 16, 1, 0, 5, 31, 9};
    int source_set[7] = '{16, 0, 1, 0, 3, 31, 16};
    wipe_system();
    reg_nodes = 16;
    reg_sources = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every kind, and the unknown, zero and range errors
    write_reg(mms_pkg::CFG_NODES, 16);
    write_reg(mms_pkg::CFG_SOURCES, 16);
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 1, 2, 0, 0, 0, 1, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 16, 0, 0, 0, 0, -1, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 3, 4, 0, 0, 0, 32'sh80000000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 5, 0, 0, 0, 0, 32'sh7fffffff, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 1, 2, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_ISRC, 1, 2, 0, 0, 0, 32'sh80000000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_ISRC, 1, 0, 0, 0, 0, 32'sh80000000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_VSRC, 1, 2, 0, 0, 0, 32'sh00050000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_VCVS, 3, 0, 1, 2, 0, 32'sh00020000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_CCVS, 0, 4, 0, 0, 15, 32'sh7fffffff, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_CCCS, 5, 6, 0, 0, 0, -3, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_VCCS, 7, 8, 9, 10, 0, 32'sh00008000, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RDMAT, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RDMAT, 0, 0, 0, 0, 0, 0, 0, 16));
    pending_items.push_back(build_item(mms_pkg::KIND_RDMAT, 0, 0, 0, 0, 0, 0, 31, 31));
    pending_items.push_back(build_item(mms_pkg::KIND_RDRHS, 0, 0, 0, 0, 0, 0, 16, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RDRHS, 0, 0, 0, 0, 0, 0, 31, 0));
    pending_items.push_back(build_item(4'd15, 31, 31, 31, 31, 15, -1, 31, 31));
    pending_items.push_back(build_item(mms_pkg::KIND_RES, 17, 1, 0, 0, 0, 5, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_VCCS, 1, 2, 31, 0, 0, 5, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_RDMAT, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Source overflow and a source-index range error with no source rows configured
    write_reg(mms_pkg::CFG_SOURCES, 0);
    pending_items.push_back(build_item(mms_pkg::KIND_VSRC, 1, 0, 0, 0, 0, 7, 0, 0));
    pending_items.push_back(build_item(mms_pkg::KIND_CCCS, 1, 0, 0, 0, 0, 7, 0, 0));
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(mms_pkg::CFG_NODES, node_set[ph]);
      write_reg(mms_pkg::CFG_SOURCES, source_set[ph]);
      if (ph == 1) long_hold_req = 1'b1;
      for (int i = 0; i < 125; i++) pending_items.push_back(random_item());
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mms_pkg.sv
hdl/mms_ram.sv
hdl/mms_front.sv
hdl/mms_queue.sv
hdl/mms_back.sv
hdl/mna_matrix_stamper.sv
bench/tb_mna_matrix_stamper.sv
